/* hw/rtl/nht_pkg.sv */
// Shared types, opcodes and status codes for the next hop table.
package nht_pkg;

  localparam int unsigned MAX_HOPS_DEF = 16;
  localparam int unsigned FACE_W       = 16;
  localparam int unsigned COST_W       = 64;
  localparam int unsigned COUNT_W      = 5;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [COST_W-1:0] cost;
  } nht_entry_t;

endpackage

/* hw/rtl/next_hop_table_core.sv */
// Top level: sequencer around the entry memory of the next hop table.
// Each request first scans the entries for its face, then executes and reads the head entry;
// add moves the old head to the entry's slot and writes the entry to the head, remove shifts
// later entries down one slot, and sort is an insertion sort by ascending cost.
// Flow: one request at a time; in_stall stays high until the result registers.
// Reset: synchronous active-low rst_n empties the list; memory contents are not cleared.
module next_hop_table_core #(
  parameter int unsigned MAX_HOPS = nht_pkg::MAX_HOPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_opcode,
  input  logic [nht_pkg::FACE_W-1:0]  in_face_id,
  input  logic [nht_pkg::COST_W-1:0]  in_hop_cost,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic                        out_hit,
  output logic [nht_pkg::COUNT_W-1:0] out_entry_count,
  output logic [nht_pkg::FACE_W-1:0]  out_head_face,
  output logic [nht_pkg::COST_W-1:0]  out_head_cost
);
  import nht_pkg::*;

  localparam int unsigned AW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int unsigned CW = $clog2(MAX_HOPS + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LRD   = 16'h0002,
    S_LCMP  = 16'h0004,
    S_EXEC  = 16'h0008,
    S_ARD   = 16'h0010,
    S_ASW   = 16'h0020,
    S_AHW   = 16'h0040,
    S_RRD   = 16'h0080,
    S_RWR   = 16'h0100,
    S_SRD   = 16'h0200,
    S_SKEY  = 16'h0400,
    S_SJRD  = 16'h0800,
    S_SJCMP = 16'h1000,
    S_HRD   = 16'h2000,
    S_DONE  = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [FACE_W-1:0] face_r, face_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              found_r, found_nxt;
  logic [1:0]        status_r, status_nxt;
  nht_entry_t        key_r, key_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [1:0]        ostatus_r, ostatus_nxt;
  logic              ohit_r, ohit_nxt;
  logic [COUNT_W-1:0] ocount_r, ocount_nxt;
  logic [FACE_W-1:0] oface_r, oface_nxt;
  logic [COST_W-1:0] ocost_r, ocost_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  nht_entry_t        wdata, rdata;
  logic [CW-1:0]     idx_inc;

  nht_mem #(.DEPTH(MAX_HOPS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    face_nxt    = face_r;
    cost_nxt    = cost_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    j_nxt       = j_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    key_nxt     = key_r;
    ovalid_nxt  = ovalid_r && out_stall;
    ostatus_nxt = ostatus_r;
    ohit_nxt    = ohit_r;
    ocount_nxt  = ocount_r;
    oface_nxt   = oface_r;
    ocost_nxt   = ocost_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    wdata       = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_opcode;
          face_nxt   = in_face_id;
          cost_nxt   = in_hop_cost;
          idx_nxt    = '0;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_LRD;
        end
      end
      S_LRD: begin
        if (idx_r < cnt_r) begin
          re        = 1'b1;
          raddr     = idx_r[AW-1:0];
          state_nxt = S_LCMP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_LCMP: begin
        if (rdata.face == face_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          state_nxt = S_EXEC;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_LRD;
        end
      end
      S_EXEC: begin
        state_nxt = S_HRD;
        case (op_r)
          OP_ADD: begin
            key_nxt = '{face: face_r, cost: cost_r};
            if (found_r) begin
              state_nxt = S_ARD;
            end else if (cnt_r >= CW'(MAX_HOPS)) begin
              status_nxt = ST_FULL;
            end else begin
              pos_nxt   = cnt_r;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_ARD;
            end
          end
          OP_REMOVE: begin
            if (found_r) begin
              idx_nxt   = pos_r;
              state_nxt = S_RRD;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          OP_QUERY: begin
            status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
          end
          OP_CLEAR: begin
            cnt_nxt = '0;
          end
          OP_SORT: begin
            idx_nxt   = CW'(1);
            state_nxt = S_SRD;
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_ARD: begin
        re        = 1'b1;
        raddr     = '0;
        state_nxt = S_ASW;
      end
      S_ASW: begin
        if (pos_r != '0) begin
          we    = 1'b1;
          waddr = pos_r[AW-1:0];
          wdata = rdata;
        end
        state_nxt = S_AHW;
      end
      S_AHW: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = key_r;
        state_nxt = S_HRD;
      end
      S_RRD: begin
        if (idx_inc < cnt_r) begin
          re        = 1'b1;
          raddr     = idx_inc[AW-1:0];
          state_nxt = S_RWR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_HRD;
        end
      end
      S_RWR: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        wdata     = rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_RRD;
      end
      S_SRD: begin
        if (idx_r < cnt_r) begin
          re        = 1'b1;
          raddr     = idx_r[AW-1:0];
          state_nxt = S_SKEY;
        end else begin
          state_nxt = S_HRD;
        end
      end
      S_SKEY: begin
        key_nxt   = rdata;
        j_nxt     = idx_r;
        state_nxt = S_SJRD;
      end
      S_SJRD: begin
        if (j_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = key_r;
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end else begin
          re        = 1'b1;
          raddr     = AW'(j_r - 1'b1);
          state_nxt = S_SJCMP;
        end
      end
      S_SJCMP: begin
        we    = 1'b1;
        waddr = j_r[AW-1:0];
        if (rdata.cost > key_r.cost) begin
          wdata     = rdata;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SJRD;
        end else begin
          wdata     = key_r;
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end
      end
      S_HRD: begin
        re        = 1'b1;
        raddr     = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = status_r;
          ohit_nxt    = found_r;
          ocount_nxt  = COUNT_W'(cnt_r);
          oface_nxt   = (cnt_r != '0) ? rdata.face : '0;
          ocost_nxt   = (cnt_r != '0) ? rdata.cost : '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    face_r    <= face_nxt;
    cost_r    <= cost_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    j_r       <= j_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    key_r     <= key_nxt;
    ostatus_r <= ostatus_nxt;
    ohit_r    <= ohit_nxt;
    ocount_r  <= ocount_nxt;
    oface_r   <= oface_nxt;
    ocost_r   <= ocost_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_hit         = ohit_r;
  assign out_entry_count = ocount_r;
  assign out_head_face   = oface_r;
  assign out_head_cost   = ocost_r;

endmodule

/* hw/rtl/nht_mem.sv */
// Simple dual-port entry memory with registered read data.
module nht_mem #(
  parameter int unsigned DEPTH = nht_pkg::MAX_HOPS_DEF,
  parameter int unsigned AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  nht_pkg::nht_entry_t wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output nht_pkg::nht_entry_t rdata
);
  import nht_pkg::*;

  nht_entry_t mem [DEPTH];
  nht_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/nht_checker.sv */
// Port-level checker for the next hop table and its bind to the top level.
module nht_checker #(
  parameter int unsigned MAX_HOPS = nht_pkg::MAX_HOPS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic                        out_hit,
  input logic [nht_pkg::COUNT_W-1:0] out_entry_count,
  input logic [nht_pkg::FACE_W-1:0]  out_head_face,
  input logic [nht_pkg::COST_W-1:0]  out_head_cost
);
  import nht_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0 |-> out_head_face == '0 && out_head_cost == '0)
    else $error("empty list shows a head entry");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      !out_hit && out_entry_count == COUNT_W'(MAX_HOPS))
    else $error("table full reported on a hit or a list that is not full");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> !out_hit)
    else $error("face not found reported on a hit");

endmodule

bind next_hop_table_core nht_checker #(.MAX_HOPS(MAX_HOPS)) u_nht_checker (.*);
